### rtl/cpu6502_pkg.sv
// ----------------------------------------------------------------------------
// cpu6502_pkg
// Opcodes, reset values and shared types for the 6502 subset executor.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

  // Supported opcodes
  localparam logic [7:0] OP_JSR_ABS = 8'h20;
  localparam logic [7:0] OP_SEC     = 8'h38;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_NOP     = 8'hEA;

  // Status register bit positions (NV-BDIZC)
  localparam int unsigned P_C = 0;
  localparam int unsigned P_Z = 1;
  localparam int unsigned P_I = 2;
  localparam int unsigned P_D = 3;
  localparam int unsigned P_V = 6;
  localparam int unsigned P_N = 7;

  localparam logic [7:0]  RST_P     = 8'h34;
  localparam logic [7:0]  RST_S     = 8'hFD;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  p;
    logic [7:0]  s;
    logic [15:0] pc;
    logic        halt;
  } arch_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [7:0]  acc_value;
    logic [7:0]  status_flags;
    logic [7:0]  stack_value;
    logic [2:0]  cycles_taken;
    logic        halted;
    logic        last_result;
  } out_beat_t;

endpackage

### rtl/cpu_6502_instruction_subset.sv
// ----------------------------------------------------------------------------
// cpu_6502_instruction_subset
// Executes one instruction of a small 6502 subset per input beat.
// ----------------------------------------------------------------------------
// Input channel (in_*): one beat per instruction carrying the opcode, the two
// following bytes and the byte read at the absolute operand address.
// Result channel (out_*): one beat per instruction, two for JSR (high byte
// push, then low byte push; last_result marks the final one).
// Path: an accepted beat is captured in the input register, executed from it
// combinationally, and registered in the result register that drives out_*.
// Throughput: one instruction per cycle while out_stall is low; JSR holds the
// result register for both pushes, so the next instruction waits behind them.
// Reset: A and X clear, P = 0x34, S = 0xFD, PC = 0, halt clear, both pipeline
// registers empty.
// Stall: while out_stall is high the result beat holds; the input register
// fills and then in_stall rises until the result side drains.
// After an unknown opcode the block halts and answers every later beat with
// one frozen-state result with cycles_taken = 0.
// ----------------------------------------------------------------------------
module cpu_6502_instruction_subset
  import cpu6502_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_operand_lo,
  input  logic [7:0]  in_operand_hi,
  input  logic [7:0]  in_load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_enable,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_data,
  output logic [15:0] out_next_pc,
  output logic [7:0]  out_acc_value,
  output logic [7:0]  out_status_flags,
  output logic [7:0]  out_stack_value,
  output logic [2:0]  out_cycles_taken,
  output logic        out_halted,
  output logic        out_last_result
);

  // input register
  logic        i_valid_r;
  logic [7:0]  i_opcode_r;
  logic [7:0]  i_lo_r;
  logic [7:0]  i_hi_r;
  logic [7:0]  i_ld_r;

  // architectural state
  arch_t       arch_r;
  arch_t       arch_nxt;
  logic [63:0] cycle_total_r;

  // result register and pending second beat
  logic        o_valid_r;
  out_beat_t   o_beat_r;
  logic        pend_r;
  out_beat_t   pend_beat_r;

  out_beat_t   beat0;
  out_beat_t   beat1;
  logic        two_beats;
  logic        advance;
  logic        in_take;
  logic        o_pop;

  cpu6502_exec u_exec (
    .cur        (arch_r),
    .opcode     (i_opcode_r),
    .operand_lo (i_lo_r),
    .operand_hi (i_hi_r),
    .load_data  (i_ld_r),
    .nxt        (arch_nxt),
    .beat0      (beat0),
    .beat1      (beat1),
    .two_beats  (two_beats)
  );

  assign o_pop    = o_valid_r && !out_stall;
  assign advance  = i_valid_r && (!o_valid_r || (o_pop && !pend_r));
  assign in_stall = i_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        i_valid_r <= 1'b1;
      end else if (advance) begin
        i_valid_r <= 1'b0;
      end
    end
    if (in_take) begin
      i_opcode_r <= in_opcode;
      i_lo_r     <= in_operand_lo;
      i_hi_r     <= in_operand_hi;
      i_ld_r     <= in_load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r.acc    <= 8'd0;
      arch_r.x      <= 8'd0;
      arch_r.p      <= RST_P;
      arch_r.s      <= RST_S;
      arch_r.pc     <= 16'd0;
      arch_r.halt   <= 1'b0;
      cycle_total_r <= 64'd0;
    end else if (advance) begin
      arch_r        <= arch_nxt;
      cycle_total_r <= cycle_total_r + {61'd0, beat0.cycles_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      if (advance) begin
        o_valid_r <= 1'b1;
        pend_r    <= two_beats;
      end else if (o_pop && pend_r) begin
        o_valid_r <= 1'b1;
        pend_r    <= 1'b0;
      end else if (o_pop) begin
        o_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      o_beat_r    <= beat0;
      pend_beat_r <= beat1;
    end else if (o_pop && pend_r) begin
      // advance the low-byte push into the result register
      o_beat_r <= pend_beat_r;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_write_enable  = o_beat_r.write_enable;
  assign out_write_address = o_beat_r.write_address;
  assign out_write_data    = o_beat_r.write_data;
  assign out_next_pc       = o_beat_r.next_pc;
  assign out_acc_value     = o_beat_r.acc_value;
  assign out_status_flags  = o_beat_r.status_flags;
  assign out_stack_value   = o_beat_r.stack_value;
  assign out_cycles_taken  = o_beat_r.cycles_taken;
  assign out_halted        = o_beat_r.halted;
  assign out_last_result   = o_beat_r.last_result;

endmodule

### rtl/cpu6502_exec.sv
// ----------------------------------------------------------------------------
// cpu6502_exec
// Decode and execute one instruction against the architectural state.
// ----------------------------------------------------------------------------
module cpu6502_exec
  import cpu6502_pkg::*;
(
  input  arch_t       cur,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand_lo,
  input  logic [7:0]  operand_hi,
  input  logic [7:0]  load_data,
  output arch_t       nxt,
  output out_beat_t   beat0,
  output out_beat_t   beat1,
  output logic        two_beats
);

  logic [15:0] abs_addr;
  logic [15:0] ret_pc;
  logic [7:0]  s_dec1;
  logic [7:0]  s_dec2;
  logic [8:0]  sum;
  logic [7:0]  res;
  logic        ovf;
  logic        we;
  logic [15:0] waddr;
  logic [7:0]  wdata;
  logic [2:0]  cyc;
  logic        set_nz;
  logic [7:0]  nz_val;

  assign abs_addr = {operand_hi, operand_lo};
  assign ret_pc   = cur.pc + 16'd2;
  assign s_dec1   = cur.s - 8'd1;
  assign s_dec2   = cur.s - 8'd2;
  assign sum      = {1'b0, cur.acc} + {1'b0, operand_lo} + {8'd0, cur.p[P_C]};
  assign res      = sum[7:0];
  assign ovf      = ~(cur.acc[7] ^ operand_lo[7]) & (cur.acc[7] ^ res[7]);

  always_comb begin
    nxt       = cur;
    we        = 1'b0;
    waddr     = 16'd0;
    wdata     = 8'd0;
    cyc       = 3'd0;
    set_nz    = 1'b0;
    nz_val    = 8'd0;
    two_beats = 1'b0;
    if (!cur.halt) begin
      case (opcode)
        OP_JSR_ABS: begin
          nxt.s     = s_dec2;
          nxt.pc    = abs_addr;
          we        = 1'b1;
          waddr     = {STACK_PAGE, cur.s};
          wdata     = ret_pc[15:8];
          cyc       = 3'd6;
          two_beats = 1'b1;
        end
        OP_SEC: begin
          nxt.p[P_C] = 1'b1;
          nxt.pc     = cur.pc + 16'd1;
          cyc        = 3'd2;
        end
        OP_JMP_ABS: begin
          nxt.pc = abs_addr;
          cyc    = 3'd3;
        end
        OP_ADC_IMM: begin
          nxt.acc    = res;
          nxt.p[P_C] = sum[8];
          nxt.p[P_V] = ovf;
          set_nz     = 1'b1;
          nz_val     = res;
          nxt.pc     = cur.pc + 16'd2;
          cyc        = 3'd2;
        end
        OP_SEI: begin
          nxt.p[P_I] = 1'b1;
          nxt.pc     = cur.pc + 16'd1;
          cyc        = 3'd2;
        end
        OP_STX_ZP: begin
          we     = 1'b1;
          waddr  = {8'd0, operand_lo};
          wdata  = cur.x;
          nxt.pc = cur.pc + 16'd2;
          cyc    = 3'd3;
        end
        OP_STA_ABS: begin
          we     = 1'b1;
          waddr  = abs_addr;
          wdata  = cur.acc;
          nxt.pc = cur.pc + 16'd3;
          cyc    = 3'd4;
        end
        OP_LDX_IMM: begin
          nxt.x  = operand_lo;
          set_nz = 1'b1;
          nz_val = operand_lo;
          nxt.pc = cur.pc + 16'd2;
          cyc    = 3'd2;
        end
        OP_LDA_IMM: begin
          nxt.acc = operand_lo;
          set_nz  = 1'b1;
          nz_val  = operand_lo;
          nxt.pc  = cur.pc + 16'd2;
          cyc     = 3'd2;
        end
        OP_LDA_ABS: begin
          nxt.acc = load_data;
          set_nz  = 1'b1;
          nz_val  = load_data;
          nxt.pc  = cur.pc + 16'd3;
          cyc     = 3'd4;
        end
        OP_CLD: begin
          nxt.p[P_D] = 1'b0;
          nxt.pc     = cur.pc + 16'd1;
          cyc        = 3'd2;
        end
        OP_NOP: begin
          nxt.pc = cur.pc + 16'd1;
          cyc    = 3'd2;
        end
        default: begin
          nxt.halt = 1'b1;
        end
      endcase
      if (set_nz) begin
        nxt.p[P_N] = nz_val[7];
        nxt.p[P_Z] = (nz_val == 8'd0);
      end
    end
  end

  always_comb begin
    beat0.write_enable  = we;
    beat0.write_address = waddr;
    beat0.write_data    = wdata;
    beat0.next_pc       = nxt.pc;
    beat0.acc_value     = nxt.acc;
    beat0.status_flags  = nxt.p;
    beat0.stack_value   = nxt.s;
    beat0.cycles_taken  = cyc;
    beat0.halted        = nxt.halt;
    beat0.last_result   = ~two_beats;

    // second push of a subroutine call: low byte of the return address
    beat1               = beat0;
    beat1.write_address = {STACK_PAGE, s_dec1};
    beat1.write_data    = ret_pc[7:0];
    beat1.last_result   = 1'b1;
  end

endmodule

### sim/tb_cpu_6502_instruction_subset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu_6502_instruction_subset
// Drives instruction beats into the 6502 subset executor and checks every
// result beat against an in-bench model of the CPU registers, under random
// idling on both channels, a long result-side hold-off, and a final halt.
// ----------------------------------------------------------------------------
module tb_cpu_6502_instruction_subset;
  import cpu6502_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PRINT_CAP    = 30;
  localparam int unsigned JSR_PCT      = 25;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_opcode = 8'h00;
  logic [7:0]  in_operand_lo = 8'h00;
  logic [7:0]  in_operand_hi = 8'h00;
  logic [7:0]  in_load_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_write_enable;
  logic [15:0] out_write_address;
  logic [7:0]  out_write_data;
  logic [15:0] out_next_pc;
  logic [7:0]  out_acc_value;
  logic [7:0]  out_status_flags;
  logic [7:0]  out_stack_value;
  logic [2:0]  out_cycles_taken;
  logic        out_halted;
  logic        out_last_result;

  cpu_6502_instruction_subset u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_operand_lo    (in_operand_lo),
    .in_operand_hi    (in_operand_hi),
    .in_load_data     (in_load_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_write_address(out_write_address),
    .out_write_data   (out_write_data),
    .out_next_pc      (out_next_pc),
    .out_acc_value    (out_acc_value),
    .out_status_flags (out_status_flags),
    .out_stack_value  (out_stack_value),
    .out_cycles_taken (out_cycles_taken),
    .out_halted       (out_halted),
    .out_last_result  (out_last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  arch_t       cpu;
  out_beat_t   predicted_beats[$];
  out_beat_t   seen_beat;
  logic        seen_take = 1'b0;
  logic        rx_hold = 1'b0;
  event        rx_hold_go;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned instr_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned jsr_count = 0;
  int unsigned stack_wraps = 0;

  // --------------------------------------------------------------------------
  // CPU model
  // --------------------------------------------------------------------------
  function automatic out_beat_t state_beat(logic we, logic [15:0] addr, logic [7:0] data,
                                           logic [2:0] cyc, logic last);
    out_beat_t b;
    b.write_enable  = we;
    b.write_address = addr;
    b.write_data    = data;
    b.next_pc       = cpu.pc;
    b.acc_value     = cpu.acc;
    b.status_flags  = cpu.p;
    b.stack_value   = cpu.s;
    b.cycles_taken  = cyc;
    b.halted        = cpu.halt;
    b.last_result   = last;
    return b;
  endfunction

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[P_N] = v[7];
    q[P_Z] = (v == 8'h00);
    return q;
  endfunction

  task automatic execute_instr(input logic [7:0] op, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] ld);
    logic [15:0] abs_addr;
    logic [15:0] ret_pc;
    logic [15:0] push_hi;
    logic [15:0] push_lo;
    logic [8:0]  sum;
    logic [2:0]  cyc;
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    abs_addr = {hi, lo};
    we = 1'b0;
    waddr = 16'h0000;
    wdata = 8'h00;
    cyc = 3'd0;
    // halted: frozen state, nothing executes
    if (cpu.halt) begin
      predicted_beats.push_back(state_beat(1'b0, 16'h0000, 8'h00, 3'd0, 1'b1));
      return;
    end
    case (op)
      OP_JSR_ABS: begin
        ret_pc  = cpu.pc + 16'd2;
        push_hi = {STACK_PAGE, cpu.s};
        push_lo = {STACK_PAGE, cpu.s - 8'd1};
        if (cpu.s < 8'd2) stack_wraps++;
        cpu.s  = cpu.s - 8'd2;
        cpu.pc = abs_addr;
        jsr_count++;
        // both beats carry the state after the whole call
        predicted_beats.push_back(state_beat(1'b1, push_hi, ret_pc[15:8], 3'd6, 1'b0));
        predicted_beats.push_back(state_beat(1'b1, push_lo, ret_pc[7:0], 3'd6, 1'b1));
        return;
      end
      OP_SEC: begin
        cpu.p[P_C] = 1'b1;
        cpu.pc = cpu.pc + 16'd1;
        cyc = 3'd2;
      end
      OP_JMP_ABS: begin
        cpu.pc = abs_addr;
        cyc = 3'd3;
      end
      OP_ADC_IMM: begin
        sum = {1'b0, cpu.acc} + {1'b0, lo} + {8'd0, cpu.p[P_C]};
        cpu.p[P_C] = sum[8];
        cpu.p[P_V] = ~(cpu.acc[7] ^ lo[7]) & (cpu.acc[7] ^ sum[7]);
        cpu.acc = sum[7:0];
        cpu.p = with_nz(cpu.p, cpu.acc);
        cpu.pc = cpu.pc + 16'd2;
        cyc = 3'd2;
      end
      OP_SEI: begin
        cpu.p[P_I] = 1'b1;
        cpu.pc = cpu.pc + 16'd1;
        cyc = 3'd2;
      end
      OP_STX_ZP: begin
        we = 1'b1;
        waddr = {8'h00, lo};
        wdata = cpu.x;
        cpu.pc = cpu.pc + 16'd2;
        cyc = 3'd3;
      end
      OP_STA_ABS: begin
        we = 1'b1;
        waddr = abs_addr;
        wdata = cpu.acc;
        cpu.pc = cpu.pc + 16'd3;
        cyc = 3'd4;
      end
      OP_LDX_IMM: begin
        cpu.x = lo;
        cpu.p = with_nz(cpu.p, lo);
        cpu.pc = cpu.pc + 16'd2;
        cyc = 3'd2;
      end
      OP_LDA_IMM: begin
        cpu.acc = lo;
        cpu.p = with_nz(cpu.p, lo);
        cpu.pc = cpu.pc + 16'd2;
        cyc = 3'd2;
      end
      OP_LDA_ABS: begin
        cpu.acc = ld;
        cpu.p = with_nz(cpu.p, ld);
        cpu.pc = cpu.pc + 16'd3;
        cyc = 3'd4;
      end
      OP_CLD: begin
        cpu.p[P_D] = 1'b0;
        cpu.pc = cpu.pc + 16'd1;
        cyc = 3'd2;
      end
      OP_NOP: begin
        cpu.pc = cpu.pc + 16'd1;
        cyc = 3'd2;
      end
      default: cpu.halt = 1'b1;
    endcase
    predicted_beats.push_back(state_beat(we, waddr, wdata, cyc, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) return 8'h00;
    if (roll < 24) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] plain_op(int unsigned idx);
    case (idx)
      0:       return OP_SEC;
      1:       return OP_JMP_ABS;
      2:       return OP_ADC_IMM;
      3:       return OP_SEI;
      4:       return OP_STX_ZP;
      5:       return OP_STA_ABS;
      6:       return OP_LDX_IMM;
      7:       return OP_LDA_IMM;
      8:       return OP_LDA_ABS;
      9:       return OP_CLD;
      default: return OP_NOP;
    endcase
  endfunction

  function automatic logic is_known(logic [7:0] op);
    case (op)
      OP_JSR_ABS, OP_SEC, OP_JMP_ABS, OP_ADC_IMM, OP_SEI, OP_STX_ZP,
      OP_STA_ABS, OP_LDX_IMM, OP_LDA_IMM, OP_LDA_ABS, OP_CLD, OP_NOP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Called just after a rising edge; returns just after the edge that took the beat.
  task automatic send_instr(input logic [7:0] op, input logic [7:0] lo,
                            input logic [7:0] hi, input logic [7:0] ld);
    logic stalled;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_operand_lo <= lo;
    in_operand_hi <= hi;
    in_load_data  <= ld;
    do begin
      @(negedge clk);
      stalled = (in_stall !== 1'b0);
      @(posedge clk);
    end while (stalled);
    instr_sent++;
    execute_instr(op, lo, hi, ld);
  endtask

  task automatic send_random_instr();
    logic [7:0] op;
    if ($urandom_range(99) < JSR_PCT) op = OP_JSR_ABS;
    else op = plain_op($urandom_range(10));
    send_instr(op, rand_byte(), rand_byte(), rand_byte());
  endtask

  // Drop valid and wait for every predicted beat to come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_beats.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic report_error(input string what, input int unsigned got,
                              input int unsigned want);
    if (error_count < PRINT_CAP)
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_error(what, 32'(got), 32'(want));
  endtask

  task automatic check_beat(input out_beat_t got_b);
    out_beat_t want;
    if (predicted_beats.size() == 0) begin
      report_error("result beat with nothing expected, next_pc", 32'(got_b.next_pc), 32'd0);
      return;
    end
    want = predicted_beats.pop_front();
    beats_checked++;
    compare_field("write_enable", 16'(got_b.write_enable), 16'(want.write_enable));
    compare_field("write_address", got_b.write_address, want.write_address);
    compare_field("write_data", 16'(got_b.write_data), 16'(want.write_data));
    compare_field("next_pc", got_b.next_pc, want.next_pc);
    compare_field("acc_value", 16'(got_b.acc_value), 16'(want.acc_value));
    compare_field("status_flags", 16'(got_b.status_flags), 16'(want.status_flags));
    compare_field("stack_value", 16'(got_b.stack_value), 16'(want.stack_value));
    compare_field("cycles_taken", 16'(got_b.cycles_taken), 16'(want.cycles_taken));
    compare_field("halted", 16'(got_b.halted), 16'(want.halted));
    compare_field("last_result", 16'(got_b.last_result), 16'(want.last_result));
  endtask

  // Sample between edges so the check never races the block's own update.
  always @(negedge clk) begin
    seen_take = (rst_n === 1'b1) && (out_valid !== 1'b0) && !out_stall;
    seen_beat.write_enable  = out_write_enable;
    seen_beat.write_address = out_write_address;
    seen_beat.write_data    = out_write_data;
    seen_beat.next_pc       = out_next_pc;
    seen_beat.acc_value     = out_acc_value;
    seen_beat.status_flags  = out_status_flags;
    seen_beat.stack_value   = out_stack_value;
    seen_beat.cycles_taken  = out_cycles_taken;
    seen_beat.halted        = out_halted;
    seen_beat.last_result   = out_last_result;
  end

  always @(posedge clk) begin
    if (seen_take) check_beat(seen_beat);
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  initial begin : rx_hold_off
    forever begin
      @(rx_hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, predicted_beats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_flag_ops();
    send_instr(OP_NOP, rand_byte(), rand_byte(), rand_byte());
    send_instr(OP_SEC, rand_byte(), rand_byte(), rand_byte());
    send_instr(OP_SEI, rand_byte(), rand_byte(), rand_byte());
    send_instr(OP_CLD, rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic test_loads_and_stores();
    send_instr(OP_LDA_IMM, 8'h00, rand_byte(), rand_byte());
    send_instr(OP_LDA_IMM, 8'h80, rand_byte(), rand_byte());
    send_instr(OP_LDX_IMM, 8'h00, rand_byte(), rand_byte());
    send_instr(OP_LDX_IMM, 8'hFF, rand_byte(), rand_byte());
    send_instr(OP_STX_ZP, 8'h00, rand_byte(), rand_byte());
    send_instr(OP_STX_ZP, 8'hFF, rand_byte(), rand_byte());
    send_instr(OP_STA_ABS, 8'h00, 8'h00, rand_byte());
    send_instr(OP_STA_ABS, 8'hFF, 8'hFF, rand_byte());
    send_instr(OP_LDA_ABS, 8'h34, 8'h12, 8'h00);
    send_instr(OP_LDA_ABS, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_adc();
    // signed overflow, carry out to zero, carry in
    send_instr(OP_LDA_IMM, 8'h7F, rand_byte(), rand_byte());
    send_instr(OP_ADC_IMM, 8'h01, rand_byte(), rand_byte());
    send_instr(OP_ADC_IMM, 8'hFF, rand_byte(), rand_byte());
    send_instr(OP_LDA_IMM, 8'hFF, rand_byte(), rand_byte());
    send_instr(OP_ADC_IMM, 8'h00, rand_byte(), rand_byte());
    send_instr(OP_ADC_IMM, 8'h80, rand_byte(), rand_byte());
  endtask

  task automatic test_jumps_and_calls();
    // PC and return address wrap past 0xFFFF
    send_instr(OP_JMP_ABS, 8'hFF, 8'hFF, rand_byte());
    send_instr(OP_LDA_IMM, 8'h01, rand_byte(), rand_byte());
    send_instr(OP_JMP_ABS, 8'hFE, 8'hFF, rand_byte());
    send_instr(OP_JSR_ABS, 8'h00, 8'h00, rand_byte());
    send_instr(OP_JSR_ABS, 8'hFF, 8'hFF, rand_byte());
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned tx_pct,
                                 input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_random_instr();
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    -> rx_hold_go;
    // keep offering beats so the input side fills and stalls
    repeat (24) send_random_instr();
    drain_results();
  endtask

  task automatic test_halt();
    logic [7:0] bad_op;
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    do bad_op = 8'($urandom_range(255)); while (is_known(bad_op));
    send_instr(bad_op, rand_byte(), rand_byte(), rand_byte());
    // every later beat is ignored, known opcodes included
    repeat (15) send_random_instr();
    repeat (15) send_instr(8'($urandom_range(255)), rand_byte(), rand_byte(), rand_byte());
    drain_results();
  endtask

  initial begin : main
    cpu.acc  = 8'h00;
    cpu.x    = 8'h00;
    cpu.p    = RST_P;
    cpu.s    = RST_S;
    cpu.pc   = 16'h0000;
    cpu.halt = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_flag_ops();
    test_loads_and_stores();
    test_adc();
    test_jumps_and_calls();
    drain_results();
    test_random_mix(350, 14, 74);
    test_random_mix(350, 74, 14);
    test_random_mix(350, 0, 0);
    test_backpressure();
    test_halt();

    repeat (10) @(posedge clk);
    if (predicted_beats.size() != 0)
      report_error("beats never delivered", 32'd0, 32'(predicted_beats.size()));
    $display("Executed %0d instructions (%0d subroutine calls, %0d stack wraps);",
             instr_sent, jsr_count, stack_wraps);
    $display("%0d beats checked over flags, ADC carry and overflow, PC wrap,", beats_checked);
    $display("back-pressure and halt.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cpu6502_pkg.sv
rtl/cpu6502_exec.sv
rtl/cpu_6502_instruction_subset.sv
sim/tb_cpu_6502_instruction_subset.sv
